/* hdl/fde_pkg.sv */
// Shared types, codes and floating point helpers of the field delta encoder.
`default_nettype none

package fde_pkg;

   // Registers between the input register and the result register.
   localparam int LANE_STAGES = 7;

   typedef enum logic [2:0] {
      CSR_FIELD_TYPE      = 3'd0,
      CSR_RESOLUTION_BITS = 3'd1,
      CSR_MAX_RANGE       = 3'd2,
      CSR_SCALE_M         = 3'd3,
      CSR_OFFSET_C        = 3'd4,
      CSR_ZEROS_ENABLE    = 3'd5,
      CSR_XOR_ENABLE      = 3'd6
   } fde_csr_type;

   typedef enum logic [2:0] {
      FT_IGNORE   = 3'd0,
      FT_UNSIGNED = 3'd1,
      FT_SIGNED   = 3'd2,
      FT_RANGED   = 3'd3,
      FT_STRICT   = 3'd4
   } fde_ftype_type;

   typedef struct packed {
      logic [31:0] base_value;
      logic [31:0] target_value;
   } fde_req_type;

   typedef struct packed {
      logic [2:0]  header_bits;
      logic [1:0]  header_length;
      logic [31:0] payload_bits;
      logic [5:0]  payload_length;
   } fde_rsp_type;

   // Per-item results that ride alongside the float lanes.
   typedef struct packed {
      logic [2:0]  hdr;
      logic [1:0]  hlen;
      logic [31:0] pay;
      logic [5:0]  plen;
      logic        strict;
      logic        xor_en;
   } fde_side_type;

   // Unpacked single: mantissa normalized (bit 23 set) for nonzero finite values.
   typedef struct packed {
      logic              sgn;
      logic signed [9:0] expo;
      logic [23:0]       man;
      logic              zero;
      logic              inf;
      logic              nan;
   } fde_unp_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] expo;
      logic [47:0]       prod;
      logic              zero;
      logic              inf;
      logic              nan;
   } fde_mul_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] expo;
      logic [26:0]       a_man;
      logic [26:0]       b_man;
      logic              sub;
      logic              zero;
      logic              inf;
      logic              nan;
   } fde_aln_type;

   typedef struct packed {
      logic              sgn;
      logic signed [9:0] expo;
      logic [27:0]       sum;
      logic [5:0]        lz;
      logic              zero;
      logic              inf;
      logic              nan;
   } fde_sum_type;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(31 - i);
      end
      return n;
   endfunction

   function automatic logic [31:0] low_mask(input logic [5:0] n);
      logic [32:0] t;
      t = (33'd1 << n) - 33'd1;
      return t[31:0];
   endfunction

   // a <= b for ordered (non-NaN) singles.
   function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
      logic r;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) r = 1'b1;
      else if (a[31] != b[31]) r = a[31];
      else if (!a[31]) r = (a[30:0] <= b[30:0]);
      else r = (a[30:0] >= b[30:0]);
      return r;
   endfunction

   function automatic fde_unp_type fp_unpack(input logic [31:0] w);
      logic [7:0]  e;
      logic [22:0] f;
      logic [5:0]  lz;
      fde_unp_type r;
      e      = w[30:23];
      f      = w[22:0];
      lz     = lzc32({1'b0, f, 8'hFF});
      r.sgn  = w[31];
      r.nan  = (e == 8'hFF) && (f != 23'd0);
      r.inf  = (e == 8'hFF) && (f == 23'd0);
      r.zero = (e == 8'd0) && (f == 23'd0);
      if (e != 8'd0) begin
         r.man  = {1'b1, f};
         r.expo = $signed({2'b00, e});
      end else begin
         r.man  = {1'b0, f} << lz;
         r.expo = 10'sd1 - $signed({4'b0000, lz});
      end
      return r;
   endfunction

   function automatic fde_mul_type fp_mul(input fde_unp_type a, input fde_unp_type b);
      fde_mul_type r;
      r.sgn  = a.sgn ^ b.sgn;
      r.expo = a.expo + b.expo - 10'sd127;
      r.prod = 48'(a.man) * 48'(b.man);
      r.nan  = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
      r.inf  = a.inf | b.inf;
      r.zero = a.zero | b.zero;
      return r;
   endfunction

   // Round the product to nearest even; underflow flushes to zero.
   function automatic fde_unp_type fp_round_prod(input fde_mul_type m);
      logic [23:0]       man;
      logic              g;
      logic              st;
      logic              rnd;
      logic [24:0]       man_r;
      logic signed [9:0] e;
      fde_unp_type       r;
      if (m.prod[47]) begin
         man = m.prod[47:24];
         g   = m.prod[23];
         st  = |m.prod[22:0];
         e   = m.expo + 10'sd1;
      end else begin
         man = m.prod[46:23];
         g   = m.prod[22];
         st  = |m.prod[21:0];
         e   = m.expo;
      end
      rnd   = g & (st | man[0]);
      man_r = {1'b0, man} + 25'(rnd);
      if (man_r[24]) begin
         man = man_r[24:1];
         e   = e + 10'sd1;
      end else begin
         man = man_r[23:0];
      end
      r.sgn  = m.sgn;
      r.expo = e;
      r.man  = man;
      r.nan  = m.nan;
      r.inf  = !m.nan && (m.inf || (!m.zero && e >= 10'sd255));
      r.zero = !m.nan && !m.inf && (m.zero || e < 10'sd1);
      return r;
   endfunction

   function automatic fde_aln_type fp_align(input fde_unp_type a, input fde_unp_type b);
      logic         a_ge;
      fde_unp_type  big;
      fde_unp_type  sml;
      logic [23:0]  sml_man;
      logic [10:0]  d;
      logic [4:0]   dc;
      logic [53:0]  sh;
      fde_aln_type  r;
      a_ge = b.zero || (!a.zero && ((a.expo > b.expo) ||
                                    (a.expo == b.expo && a.man >= b.man)));
      big     = a_ge ? a : b;
      sml     = a_ge ? b : a;
      sml_man = sml.zero ? 24'd0 : sml.man;
      d       = 11'($signed({big.expo[9], big.expo}) - $signed({sml.expo[9], sml.expo}));
      if (d[10]) dc = 5'd0;
      else if (d >= 11'd27) dc = 5'd27;
      else dc = d[4:0];
      sh      = {sml_man, 30'd0} >> dc;
      r.a_man = {big.man, 3'b000};
      r.b_man = {sh[53:28], sh[27] | (|sh[26:0])};
      r.sub   = a.sgn ^ b.sgn;
      r.expo  = big.expo;
      r.nan   = a.nan | b.nan | (a.inf & b.inf & (a.sgn ^ b.sgn));
      r.inf   = !r.nan && (a.inf || b.inf);
      r.sgn   = r.inf ? (a.inf ? a.sgn : b.sgn) : big.sgn;
      r.zero  = a.zero & b.zero;
      return r;
   endfunction

   function automatic fde_sum_type fp_addsub(input fde_aln_type a);
      fde_sum_type r;
      r.sum  = a.sub ? ({1'b0, a.a_man} - {1'b0, a.b_man})
                     : ({1'b0, a.a_man} + {1'b0, a.b_man});
      r.lz   = lzc32({r.sum[26:0], 5'h1F});
      r.sgn  = a.sgn;
      r.expo = a.expo;
      r.zero = a.zero;
      r.inf  = a.inf;
      r.nan  = a.nan;
      return r;
   endfunction

   function automatic fde_unp_type fp_norm_round(input fde_sum_type s);
      logic [26:0]       n;
      logic signed [9:0] e;
      logic [23:0]       man;
      logic              g;
      logic              st;
      logic              rnd;
      logic [24:0]       man_r;
      fde_unp_type       r;
      if (s.sum[27]) begin
         n = {s.sum[27:2], s.sum[1] | s.sum[0]};
         e = s.expo + 10'sd1;
      end else begin
         n = s.sum[26:0] << s.lz;
         e = s.expo - $signed({4'b0000, s.lz});
      end
      man   = n[26:3];
      g     = n[2];
      st    = |n[1:0];
      rnd   = g & (st | man[0]);
      man_r = {1'b0, man} + 25'(rnd);
      if (man_r[24]) begin
         man = man_r[24:1];
         e   = e + 10'sd1;
      end else begin
         man = man_r[23:0];
      end
      r.sgn  = s.sgn;
      r.expo = e;
      r.man  = man;
      r.nan  = s.nan;
      r.inf  = !s.nan && s.inf;
      r.zero = !s.nan && !s.inf && (s.zero || s.sum == 28'd0);
      return r;
   endfunction

   // Truncate toward zero; NaN and negatives give 0, 2^32 and up saturate.
   function automatic logic [31:0] fp_to_uint(input fde_unp_type f);
      logic [4:0]  k;
      logic [31:0] u;
      k = 5'(f.expo - 10'sd127);
      if (f.nan || f.zero || f.sgn) u = 32'd0;
      else if (f.inf || f.expo >= 10'sd159) u = 32'hFFFF_FFFF;
      else if (f.expo < 10'sd127) u = 32'd0;
      else if (k >= 5'd23) u = {8'd0, f.man} << (k - 5'd23);
      else u = {8'd0, f.man} >> (5'd23 - k);
      return u;
   endfunction

endpackage

`default_nettype wire

/* hdl/fde_scale_lane.sv */
// Pipelined single precision x*m+c followed by saturating conversion to unsigned.
`default_nettype none

module fde_scale_lane (
   input  logic                               clock,
   input  logic [fde_pkg::LANE_STAGES-1:0]    stage_en,
   input  logic [31:0]                        x_value,
   input  logic [31:0]                        scale_m,
   input  logic [31:0]                        offset_c,
   output logic [31:0]                        u_value
);

   fde_pkg::fde_unp_type x_in, x_ff, m_in, m_ff;
   fde_pkg::fde_mul_type mul_in, mul_ff;
   fde_pkg::fde_unp_type prd_in, prd_ff;
   fde_pkg::fde_aln_type aln_in, aln_ff;
   fde_pkg::fde_sum_type sum_in, sum_ff;
   fde_pkg::fde_unp_type res_in, res_ff;
   logic [31:0]          u_in, u_ff;

   always_comb begin
      x_in   = fde_pkg::fp_unpack(x_value);
      m_in   = fde_pkg::fp_unpack(scale_m);
      mul_in = fde_pkg::fp_mul(x_ff, m_ff);
      prd_in = fde_pkg::fp_round_prod(mul_ff);
      aln_in = fde_pkg::fp_align(prd_ff, fde_pkg::fp_unpack(offset_c));
      sum_in = fde_pkg::fp_addsub(aln_ff);
      res_in = fde_pkg::fp_norm_round(sum_ff);
      u_in   = fde_pkg::fp_to_uint(res_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff <= x_in;
         m_ff <= m_in;
      end
      if (stage_en[1]) mul_ff <= mul_in;
      if (stage_en[2]) prd_ff <= prd_in;
      if (stage_en[3]) aln_ff <= aln_in;
      if (stage_en[4]) sum_ff <= sum_in;
      if (stage_en[5]) res_ff <= res_in;
      if (stage_en[6]) u_ff   <= u_in;
   end

   assign u_value = u_ff;

endmodule

`default_nettype wire

/* hdl/field_delta_encoder_unit.sv */
// Field delta encoder top level: config registers, item pipeline and result register.
`default_nettype none

// Encodes one 32-bit field word against its base word per item and returns a
// header of one to three flags plus a payload of up to 32 bits with lengths.
// Throughput is one item per clock while rsp_stall is low; an accepted item
// passes the input register, seven stages of the strict-float path and the
// result register. The depth comes from the single precision x*m+c
// path: unpack, 24x24 multiply, product rounding, alignment, add, normalize
// and round, unsigned conversion. Target and base each have their own lane.
// Every stage holds its item under back-pressure and bubbles collapse, so an
// item is taken whenever a stage ahead can move. Other field types are
// resolved at the input register and ride alongside the float lanes.
// Configuration must be written while no item is in flight.

module field_delta_encoder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fde_pkg::fde_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fde_pkg::fde_rsp_type  rsp_data,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam int NS = fde_pkg::LANE_STAGES;

   // config registers
   logic [2:0]  field_type_ff;
   logic [5:0]  resolution_ff;
   logic [31:0] max_range_ff;
   logic [31:0] scale_m_ff;
   logic [31:0] offset_c_ff;
   logic        zeros_en_ff;
   logic        xor_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_type_ff <= fde_pkg::FT_UNSIGNED;
         resolution_ff <= 6'd32;
         max_range_ff  <= 32'd0;
         scale_m_ff    <= 32'h3F80_0000;
         offset_c_ff   <= 32'd0;
         zeros_en_ff   <= 1'b0;
         xor_en_ff     <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            fde_pkg::CSR_FIELD_TYPE:      field_type_ff <= csr_wdata[2:0];
            fde_pkg::CSR_RESOLUTION_BITS: resolution_ff <= csr_wdata[5:0];
            fde_pkg::CSR_MAX_RANGE:       max_range_ff  <= csr_wdata;
            fde_pkg::CSR_SCALE_M:         scale_m_ff    <= csr_wdata;
            fde_pkg::CSR_OFFSET_C:        offset_c_ff   <= csr_wdata;
            fde_pkg::CSR_ZEROS_ENABLE:    zeros_en_ff   <= csr_wdata[0];
            fde_pkg::CSR_XOR_ENABLE:      xor_en_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---- stage enables: a stage loads when empty or when the next one loads
   logic                 in_valid_ff;
   fde_pkg::fde_req_type in_ff;
   logic [NS-1:0]        pipe_vld_ff;
   logic [NS-1:0]        en_pipe;
   logic                 en_in;
   logic                 en_rsp;
   logic                 rsp_valid_ff;
   fde_pkg::fde_rsp_type rsp_in, rsp_ff;

   always_comb begin
      en_rsp          = !rsp_valid_ff || !rsp_stall;
      en_pipe[NS-1]   = !pipe_vld_ff[NS-1] || en_rsp;
      for (int k = NS - 2; k >= 0; k--) begin
         en_pipe[k] = !pipe_vld_ff[k] || en_pipe[k+1];
      end
      en_in = !in_valid_ff || en_pipe[0];
   end

   assign req_stall = !en_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pipe_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_in) in_valid_ff <= req_valid;
         if (en_pipe[0]) pipe_vld_ff[0] <= in_valid_ff;
         for (int k = 1; k < NS; k++) begin
            if (en_pipe[k]) pipe_vld_ff[k] <= pipe_vld_ff[k-1];
         end
         if (en_rsp) rsp_valid_ff <= pipe_vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_in) in_ff <= req_data;
   end

   // ---- header and non-strict payload, resolved from the input register
   fde_pkg::fde_side_type side_in;
   fde_pkg::fde_side_type side_ff [NS];

   logic [31:0] tgt;
   logic [31:0] bas;
   logic [5:0]  res;
   logic [7:0]  t_exp;
   logic [23:0] t_man;
   logic [7:0]  rsh;
   logic [4:0]  lsh;
   logic [31:0] frac_mask;
   logic        in_rng;
   logic        integral;
   logic [31:0] mag;
   logic [31:0] ival;
   logic        mr_nan;
   logic        as_int;

   always_comb begin
      tgt    = in_ff.target_value;
      bas    = in_ff.base_value;
      res    = (resolution_ff > 6'd32) ? 6'd32 : resolution_ff;
      t_exp  = tgt[30:23];
      t_man  = {1'b1, tgt[22:0]};
      rsh    = 8'd150 - t_exp;
      lsh    = 5'(t_exp - 8'd150);
      frac_mask = fde_pkg::low_mask(rsh[5:0]);
      // magnitude below 2^31, or exactly -2^31
      in_rng = (t_exp < 8'd158) || (tgt == 32'hCF00_0000);
      if (t_exp >= 8'd150) begin
         integral = 1'b1;
         mag      = {8'd0, t_man} << lsh;
      end else if (t_exp < 8'd127) begin
         integral = (tgt[30:0] == 31'd0);
         mag      = 32'd0;
      end else begin
         integral = ((tgt[22:0] & frac_mask[22:0]) == 23'd0);
         mag      = {8'd0, t_man} >> rsh[4:0];
      end
      ival   = tgt[31] ? (~mag + 32'd1) : mag;
      mr_nan = (max_range_ff[30:23] == 8'hFF) && (max_range_ff[22:0] != 23'd0);
      as_int = in_rng && integral &&
               (mr_nan || (fde_pkg::fp_le(tgt, max_range_ff) &&
                           fde_pkg::fp_le({~max_range_ff[31], max_range_ff[30:0]}, tgt)));

      side_in        = '0;
      side_in.hlen   = 2'd1;
      side_in.xor_en = xor_en_ff;
      if (bas == tgt) begin
         side_in.hdr = 3'd1;                       // unchanged
      end else if (zeros_en_ff && tgt == 32'd0) begin
         side_in.hdr  = 3'd1;                      // zero flag
         side_in.hlen = 2'd2;
      end else begin
         if (zeros_en_ff) side_in.hlen = 2'd2;
         if (field_type_ff == fde_pkg::FT_RANGED) begin
            side_in.hlen = side_in.hlen + 2'd1;
            if (as_int) begin
               side_in.pay  = ival & fde_pkg::low_mask(res);
               side_in.plen = res;
            end else begin
               side_in.hdr  = 3'd1;                // full float
               side_in.pay  = xor_en_ff ? (bas ^ tgt) : tgt;
               side_in.plen = 6'd32;
            end
         end else if (field_type_ff == fde_pkg::FT_UNSIGNED ||
                      field_type_ff == fde_pkg::FT_SIGNED ||
                      field_type_ff == fde_pkg::FT_STRICT) begin
            side_in.pay    = (xor_en_ff ? (bas ^ tgt) : tgt) & fde_pkg::low_mask(res);
            side_in.plen   = res;
            side_in.strict = (field_type_ff == fde_pkg::FT_STRICT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_pipe[0]) side_ff[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
         if (en_pipe[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   // ---- strict float lanes
   logic [31:0] u_tgt;
   logic [31:0] u_bas;

   fde_scale_lane u_lane_tgt (
      .clock    (clock),
      .stage_en (en_pipe),
      .x_value  (in_ff.target_value),
      .scale_m  (scale_m_ff),
      .offset_c (offset_c_ff),
      .u_value  (u_tgt)
   );

   fde_scale_lane u_lane_bas (
      .clock    (clock),
      .stage_en (en_pipe),
      .x_value  (in_ff.base_value),
      .scale_m  (scale_m_ff),
      .offset_c (offset_c_ff),
      .u_value  (u_bas)
   );

   // ---- result register
   always_comb begin
      rsp_in.header_bits    = side_ff[NS-1].hdr;
      rsp_in.header_length  = side_ff[NS-1].hlen;
      rsp_in.payload_length = side_ff[NS-1].plen;
      if (side_ff[NS-1].strict)
         rsp_in.payload_bits = (side_ff[NS-1].xor_en ? (u_bas ^ u_tgt) : u_tgt) &
                               fde_pkg::low_mask(side_ff[NS-1].plen);
      else
         rsp_in.payload_bits = side_ff[NS-1].pay;
   end

   always_ff @(posedge clock) begin
      if (en_rsp) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_hlen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.header_length != 2'd0)
      else $error("header length zero");

   a_plen_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.payload_length <= 6'd32)
      else $error("payload length above 32");

   a_unchanged_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.header_length == 2'd1 && rsp_ff.header_bits == 3'd1)
      |-> rsp_ff.payload_length == 6'd0)
      else $error("unchanged item carries payload");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.payload_length < 6'd32)
      |-> (rsp_ff.payload_bits >> rsp_ff.payload_length) == 32'd0)
      else $error("payload bits above length");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && en_pipe[0]) |=> pipe_vld_ff[0])
      else $error("item lost leaving input register");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the field delta encoder unit.
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   fde_pkg::fde_req_type  req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   fde_pkg::fde_rsp_type  rsp_data;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic [31:0]           csr_wdata;

   field_delta_encoder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the register file, updated as each write goes out.
   logic [2:0]  cfg_ftype;
   logic [5:0]  cfg_res;
   logic [31:0] cfg_max_range;
   logic [31:0] cfg_scale;
   logic [31:0] cfg_offset;
   logic        cfg_zeros;
   logic        cfg_xor;

   fde_pkg::fde_req_type pending_items[$];
   fde_pkg::fde_rsp_type expected_codes[$];
   int          mismatches;
   int          idle_cycles;
   bit          quiet;
   int          send_gap;
   int          stall_gap;

   // ---------------- single precision helpers ----------------

   // Single bit pattern to an exact double.
   function automatic real single_to_real(input logic [31:0] w);
      logic [63:0] d;
      logic [22:0] f;
      int          p;
      f = w[22:0];
      d = '0;
      d[63] = w[31];
      if (w[30:23] == 8'hFF) begin
         d[62:52] = 11'h7FF;
         if (f != 0) d[51] = 1'b1;
      end else if (w[30:23] != 0) begin
         d[62:52] = 11'(w[30:23]) + 11'd896;
         d[51:29] = f;
      end else if (f != 0) begin
         p = 0;
         for (int i = 0; i < 23; i++) if (f[i]) p = i;
         d[62:52] = 11'(p - 149 + 1023);
         d[51:0]  = 52'({29'd0, f} << (52 - p));
      end
      return $bitstoreal(d);
   endfunction

   // Double to single, round to nearest even, subnormals kept.
   function automatic logic [31:0] real_to_single(input real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] bits;
      longint      ex;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? {d[63], 8'hFF, 23'h400000} : {d[63], 8'hFF, 23'h0};
      if (d[62:52] == 0) return {d[63], 31'd0};
      ex = longint'(d[62:52]) - 1023;
      if (ex > 127) return {d[63], 8'hFF, 23'h0};
      m  = {11'd1, d[51:0]};
      sh = (ex >= -126) ? 29 : 29 + int'(-126 - ex);
      if (sh > 60) return {d[63], 31'd0};
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      bits = (ex >= -126) ? ((64'(ex + 126) << 23) + q) : q;
      if (bits >= 64'h7F80_0000) return {d[63], 8'hFF, 23'h0};
      return {d[63], bits[30:0]};
   endfunction

   // x*m+c in single precision, then truncation to unsigned with saturation.
   function automatic logic [31:0] scaled_unsigned(input logic [31:0] x);
      logic [31:0] prod;
      logic [31:0] s;
      logic [23:0] man;
      int          k;
      prod = real_to_single(single_to_real(x) * single_to_real(cfg_scale));
      s    = real_to_single(single_to_real(prod) + single_to_real(cfg_offset));
      if (s[30:23] == 8'hFF && s[22:0] != 0) return 32'd0;
      if (s[31] || s[30:0] == 0) return 32'd0;
      if (s[30:23] == 8'hFF || s[30:23] >= 8'd159) return 32'hFFFF_FFFF;
      if (s[30:23] < 8'd127) return 32'd0;
      man = {1'b1, s[22:0]};
      k   = int'(s[30:23]) - 127;
      return (k >= 23) ? (32'(man) << (k - 23)) : (32'(man) >> (23 - k));
   endfunction

   // ---------------- encoder predictor ----------------
   function automatic fde_pkg::fde_rsp_type encode_field(input fde_pkg::fde_req_type it);
      fde_pkg::fde_rsp_type r;
      logic [31:0] b;
      logic [31:0] t;
      logic [31:0] mask;
      logic [5:0]  res;
      real         ft;
      real         mr;
      int          iv;
      bit          as_int;
      res  = (cfg_res > 6'd32) ? 6'd32 : cfg_res;
      mask = 32'((64'd1 << res) - 64'd1);
      r    = '0;
      b    = it.base_value;
      t    = it.target_value;
      r.header_length = 2'd1;
      if (b == t) begin
         r.header_bits = 3'd1;
      end else if (cfg_zeros && t == 0) begin
         r.header_bits   = 3'd1;
         r.header_length = 2'd2;
      end else begin
         if (cfg_zeros) r.header_length = 2'd2;
         if (cfg_ftype == fde_pkg::FT_RANGED) begin
            as_int = 0;
            iv     = 0;
            if (t[30:23] != 8'hFF) begin
               ft = single_to_real(t);
               if (ft >= -2147483648.0 && ft < 2147483648.0) begin
                  iv = $rtoi(ft);
                  if ($itor(iv) == ft) begin
                     as_int = 1;
                     // a NaN limit bounds nothing
                     if (!(cfg_max_range[30:23] == 8'hFF && cfg_max_range[22:0] != 0)) begin
                        mr = single_to_real(cfg_max_range);
                        if (ft > mr || ft < -mr) as_int = 0;
                     end
                  end
               end
            end
            r.header_length = r.header_length + 2'd1;
            r.header_bits   = as_int ? 3'd0 : 3'd1;
            if (as_int) begin
               r.payload_bits   = 32'(iv) & mask;
               r.payload_length = res;
            end else begin
               r.payload_bits   = cfg_xor ? (b ^ t) : t;
               r.payload_length = 6'd32;
            end
         end else if (cfg_ftype >= fde_pkg::FT_UNSIGNED && cfg_ftype <= fde_pkg::FT_STRICT) begin
            if (cfg_ftype == fde_pkg::FT_STRICT) begin
               t = scaled_unsigned(t);
               b = scaled_unsigned(b);
            end
            r.payload_bits   = (cfg_xor ? (b ^ t) : t) & mask;
            r.payload_length = res;
         end
      end
      return r;
   endfunction

   // ---------------- stimulus sources ----------------
   function automatic logic [31:0] pick_word();
      logic [31:0] specials[12];
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h4F00_0000,
                   32'hCF00_0000, 32'h4EFF_FFFF, 32'hFFFF_FFFF, 32'h3F00_0000};
      case ($urandom_range(0, 7))
         0, 1: return real_to_single($itor($signed($urandom_range(0, 2000)) - 1000));
         2:    return real_to_single($itor($signed($urandom)));
         3:    return real_to_single($itor($signed($urandom_range(0, 400)) - 200) + 0.5);
         4:    return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 165)),
                       23'($urandom)};
         5:    return specials[$urandom_range(0, 11)];
         default: return $urandom;
      endcase
   endfunction

   function automatic fde_pkg::fde_req_type pick_item();
      fde_pkg::fde_req_type it;
      it.base_value = pick_word();
      case ($urandom_range(0, 7))
         0:       it.target_value = it.base_value;
         1:       it.target_value = 32'd0;
         default: it.target_value = pick_word();
      endcase
      return it;
   endfunction

   task automatic write_reg(input fde_pkg::fde_csr_type idx, input logic [31:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         fde_pkg::CSR_FIELD_TYPE:      cfg_ftype     = v[2:0];
         fde_pkg::CSR_RESOLUTION_BITS: cfg_res       = v[5:0];
         fde_pkg::CSR_MAX_RANGE:       cfg_max_range = v;
         fde_pkg::CSR_SCALE_M:         cfg_scale     = v;
         fde_pkg::CSR_OFFSET_C:        cfg_offset    = v;
         fde_pkg::CSR_ZEROS_ENABLE:    cfg_zeros     = v[0];
         fde_pkg::CSR_XOR_ENABLE:      cfg_xor       = v[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Let everything queued go out and come back, plus pipeline slack.
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_codes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic setup(input logic [2:0] ft, input logic [5:0] res, input logic [31:0] mr,
                        input logic [31:0] m, input logic [31:0] c, input bit z, input bit x);
      write_reg(fde_pkg::CSR_FIELD_TYPE, 32'(ft));
      write_reg(fde_pkg::CSR_RESOLUTION_BITS, 32'(res));
      write_reg(fde_pkg::CSR_MAX_RANGE, mr);
      write_reg(fde_pkg::CSR_SCALE_M, m);
      write_reg(fde_pkg::CSR_OFFSET_C, c);
      write_reg(fde_pkg::CSR_ZEROS_ENABLE, 32'(z));
      write_reg(fde_pkg::CSR_XOR_ENABLE, 32'(x));
   endtask

   // ---------------- clock, reset, sequence ----------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      fde_pkg::fde_req_type d;
      reset     = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet     = 0;
      cfg_ftype = fde_pkg::FT_UNSIGNED;
      cfg_res   = 6'd32;
      cfg_max_range = 32'd0;
      cfg_scale = 32'h3F80_0000;
      cfg_offset = 32'd0;
      cfg_zeros = 1'b0;
      cfg_xor   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, ranged float corner values, then strict scaling corners.
      pending_items.push_back('{32'h0, 32'h0});
      pending_items.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      pending_items.push_back('{32'h0, 32'hFFFF_FFFF});
      pending_items.push_back('{32'hFFFF_FFFF, 32'h0});
      pending_items.push_back('{32'h1234_5678, 32'h8765_4321});
      drain();
      setup(fde_pkg::FT_RANGED, 6'd8, 32'h4120_0000, 32'h3F80_0000, 32'h0, 1'b1, 1'b1);
      pending_items.push_back('{32'h1, 32'h4120_0000});   // +10 at the limit
      pending_items.push_back('{32'h1, 32'hC120_0000});   // -10 at the limit
      pending_items.push_back('{32'h1, 32'h4130_0000});   // 11, beyond the limit
      pending_items.push_back('{32'h1, 32'h3FC0_0000});   // fractional
      pending_items.push_back('{32'h1, 32'h7FC0_0000});   // NaN
      pending_items.push_back('{32'h1, 32'hFF80_0000});   // -inf
      pending_items.push_back('{32'h1, 32'h0});           // zero flag
      pending_items.push_back('{32'h1, 32'h8000_0000});   // negative zero
      pending_items.push_back('{32'h5, 32'h5});           // unchanged
      drain();
      setup(fde_pkg::FT_RANGED, 6'd32, 32'h7FC0_0000, 32'h3F80_0000, 32'h0, 1'b0, 1'b0);
      pending_items.push_back('{32'h1, 32'hCF00_0000});   // -2^31 fits
      pending_items.push_back('{32'h1, 32'h4F00_0000});   // 2^31 does not
      pending_items.push_back('{32'h1, 32'h4EFF_FFFF});
      drain();
      setup(fde_pkg::FT_STRICT, 6'd32, 32'h0, 32'h4F80_0000, 32'h3F00_0000, 1'b0, 1'b0);
      pending_items.push_back('{32'h3F80_0000, 32'h4000_0000}); // saturates
      pending_items.push_back('{32'h3F80_0000, 32'hBF80_0000}); // negative -> 0
      pending_items.push_back('{32'h3F80_0000, 32'h7FC0_0000}); // NaN -> 0
      pending_items.push_back('{32'h3F80_0000, 32'h3000_0000}); // tiny
      drain();

      // Random phases over a spread of settings, extremes included.
      for (int ph = 0; ph < 15; ph++) begin
         case (ph)
            0:  setup(fde_pkg::FT_IGNORE, 6'd32, 32'h0, 32'h3F80_0000, 32'h0, 1'b1, 1'b0);
            1:  setup(fde_pkg::FT_UNSIGNED, 6'd1, 32'h0, 32'h3F80_0000, 32'h0, 1'b0, 1'b1);
            2:  setup(fde_pkg::FT_SIGNED, 6'd0, 32'h0, 32'h3F80_0000, 32'h0, 1'b1, 1'b1);
            3:  setup(fde_pkg::FT_SIGNED, 6'd63, 32'h0, 32'h3F80_0000, 32'h0, 1'b0, 1'b0);
            4:  setup(fde_pkg::FT_RANGED, 6'd16, 32'h447A_0000, 32'h0, 32'h0, 1'b1, 1'b0);
            5:  setup(fde_pkg::FT_RANGED, 6'd0, 32'h7F80_0000, 32'h0, 32'h0, 1'b0, 1'b1);
            6:  setup(fde_pkg::FT_RANGED, 6'd40, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1);
            7:  setup(fde_pkg::FT_STRICT, 6'd12, 32'h0, 32'h4120_0000, 32'h4220_0000,
                      1'b0, 1'b0);
            8:  setup(fde_pkg::FT_STRICT, 6'd32, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1'b1, 1'b1);
            9:  setup(fde_pkg::FT_STRICT, 6'd20, 32'h0, 32'h0000_0001, 32'h0, 1'b0, 1'b1);
            10: setup(3'd5, 6'd32, 32'h0, 32'h3F80_0000, 32'h0, 1'b1, 1'b0);
            11: setup(3'd7, 6'd8, 32'h0, 32'h3F80_0000, 32'h0, 1'b0, 1'b1);
            12: setup(fde_pkg::FT_STRICT, 6'($urandom_range(1, 32)), $urandom,
                      {1'b0, 8'($urandom_range(110, 140)), 23'($urandom)},
                      {1'b0, 8'($urandom_range(110, 150)), 23'($urandom)}, 1'b1, 1'b0);
            13: setup(fde_pkg::FT_RANGED, 6'($urandom_range(1, 32)),
                      real_to_single($itor($urandom_range(0, 1000))), $urandom, $urandom,
                      1'b0, 1'b0);
            default: begin
               quiet = 1;  // closing stretch runs at full rate
               setup(3'($urandom_range(1, 4)), 6'($urandom_range(1, 32)),
                     real_to_single($itor($urandom_range(0, 100000))),
                     32'h3F80_0000, 32'h0, 1'b1, 1'b1);
            end
         endcase
         for (int n = 0; n < 70; n++) begin
            d = pick_item();
            pending_items.push_back(d);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // ---------------- driver: request side ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_codes.push_back(encode_field(req_data));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
               send_gap  <= $urandom_range(0, 10);
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor: result side ----------------
   always @(posedge clock) begin
      fde_pkg::fde_rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_gap  <= 0;
         mismatches <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result %p", rsp_data);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_data !== want) begin
                  if (mismatches < 10)
                     $display("mismatch: expected %p got %p", want, rsp_data);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            stall_gap <= $urandom_range(0, 10);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

endmodule

/* files.f */
hdl/fde_pkg.sv
hdl/fde_scale_lane.sv
hdl/field_delta_encoder_unit.sv
dv/tb.sv
